/* src/sprite_velocity_physics_step_assert.svh */
// Assertion macros used by the sprite physics controller.
`ifndef SPRITE_VELOCITY_PHYSICS_STEP_ASSERT_SVH
`define SPRITE_VELOCITY_PHYSICS_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svps assertion failed");

// Next-cycle implication, checked outside reset.
`define SVPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svps assertion failed");

`endif

/* src/svps_pkg.sv */
// Package with the shared types and constants of the sprite physics block.
`default_nettype none
package svps_pkg;

    localparam logic [1:0] OP_FORCE = 2'd0;
    localparam logic [1:0] OP_DRAG  = 2'd1;
    localparam logic [1:0] OP_BOUND = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] REG_ACCEL  = 3'd0;
    localparam logic [2:0] REG_VMAX   = 3'd1;
    localparam logic [2:0] REG_VMIN   = 3'd2;
    localparam logic [2:0] REG_DRAG   = 3'd3;
    localparam logic [2:0] REG_WIN_W  = 3'd4;
    localparam logic [2:0] REG_WIN_H  = 3'd5;
    localparam logic [2:0] REG_SPR_W  = 3'd6;
    localparam logic [2:0] REG_SPR_H  = 3'd7;

    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_ACC_MUL,
        ST_ACC_FIN,
        ST_DRAG_MUL,
        ST_DRAG_FIN,
        ST_BOUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic move;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic acc_mul;
        logic acc_fin;
        logic drag_mul;
        logic drag_fin;
        logic bound;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       n2_zero;
        logic       out_stall;
    } status_t;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/svps_ctrl.sv */
// Controller state machine that sequences the sprite physics datapath.
`default_nettype none
module svps_ctrl
    import svps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    `include "sprite_velocity_physics_step_assert.svh"

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (status.op)
                    OP_FORCE: state_next = ST_MOVE;
                    OP_DRAG:  state_next = ST_DRAG_MUL;
                    OP_BOUND: state_next = ST_BOUND;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_MOVE:
            begin
                cnt_next   = '0;
                state_next = status.n2_zero ? ST_ACC_MUL : ST_SQRT;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_LAST) state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST) state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL:  state_next = ST_ACC_FIN;
            ST_ACC_FIN:  state_next = ST_FINISH;
            ST_DRAG_MUL: state_next = ST_DRAG_FIN;
            ST_DRAG_FIN: state_next = ST_FINISH;
            ST_BOUND:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_stall) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_ready      = (state_reg == ST_IDLE);
        cmd.load_in   = (state_reg == ST_IDLE) && in_valid;
        cmd.move      = (state_reg == ST_MOVE);
        cmd.sqrt_step = (state_reg == ST_SQRT);
        cmd.div_init  = (state_reg == ST_DIV_INIT);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.acc_mul   = (state_reg == ST_ACC_MUL);
        cmd.acc_fin   = (state_reg == ST_ACC_FIN);
        cmd.drag_mul  = (state_reg == ST_DRAG_MUL);
        cmd.drag_fin  = (state_reg == ST_DRAG_FIN);
        cmd.bound     = (state_reg == ST_BOUND);
        cmd.out_load  = (state_reg == ST_FINISH) && !status.out_stall;
    end

    `SVPS_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_reg == ST_DECODE)
    `SVPS_ASSERT_IMP(a_div_count, state_reg == ST_DIV, cnt_reg <= DIV_LAST)
    `SVPS_ASSERT_NXT(a_div_done, state_reg == ST_DIV && cnt_reg == DIV_LAST,
        state_reg == ST_ACC_MUL)
    `SVPS_ASSERT_NXT(a_sqrt_done, state_reg == ST_SQRT && cnt_reg == SQRT_LAST,
        state_reg == ST_DIV_INIT)

endmodule
`default_nettype wire

/* src/svps_dp.sv */
// Datapath of the sprite physics block: state, settings, root, divide, multiply.
`default_nettype none
module svps_dp
    import svps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          status,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_data,
    input  wire logic [1:0]  in_op,
    input  wire logic [15:0] in_dir_x,
    input  wire logic [15:0] in_dir_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [127:0]     out_data
);

    logic [31:0] accel_reg;
    logic [30:0] vmax_reg;
    logic [30:0] vmin_reg;
    logic [16:0] drag_reg;
    logic [15:0] win_w_reg, win_h_reg, spr_w_reg, spr_h_reg;

    logic [1:0]         op_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [31:0]        pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [63:0]        rad_reg, root_reg, bit_reg;
    logic [31:0]        len_reg;
    logic [32:0]        rem_x_reg, rem_y_reg;
    logic [16:0]        q_x_reg, q_y_reg;
    logic [48:0]        prod_x_reg, prod_y_reg;
    logic [127:0]       out_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= 32'd65536;
            vmax_reg  <= 31'd655360;
            vmin_reg  <= 31'd6554;
            drag_reg  <= 17'd62259;
            win_w_reg <= 16'd800;
            win_h_reg <= 16'd600;
            spr_w_reg <= 16'd32;
            spr_h_reg <= 16'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ACCEL: accel_reg <= cfg_data;
                REG_VMAX:  vmax_reg  <= cfg_data[30:0];
                REG_VMIN:  vmin_reg  <= cfg_data[30:0];
                REG_DRAG:  drag_reg  <= cfg_data[16:0];
                REG_WIN_W: win_w_reg <= cfg_data[15:0];
                REG_WIN_H: win_h_reg <= cfg_data[15:0];
                REG_SPR_W: spr_w_reg <= cfg_data[15:0];
                REG_SPR_H: spr_h_reg <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    logic [31:0] sq_x, sq_y, n2;
    assign sq_x = 32'(dx_reg * dx_reg);
    assign sq_y = 32'(dy_reg * dy_reg);
    assign n2   = sq_x + sq_y;

    logic [63:0] trial;
    logic        take;
    assign trial = root_reg + bit_reg;
    assign take  = (rad_reg >= trial);

    logic [15:0] ax, ay;
    assign ax = dx_reg[15] ? 16'(-dx_reg) : 16'(dx_reg);
    assign ay = dy_reg[15] ? 16'(-dy_reg) : 16'(dy_reg);

    logic [32:0] tx, ty;
    logic        gx, gy;
    assign tx = {rem_x_reg[31:0], 1'b0};
    assign ty = {rem_y_reg[31:0], 1'b0};
    assign gx = (tx >= {1'b0, len_reg});
    assign gy = (ty >= {1'b0, len_reg});

    function automatic logic [31:0] acc_axis(input logic [31:0] v, input logic neg,
                                             input logic [48:0] p, input logic [30:0] lim);
        logic signed [34:0] inc, sum, l;
        inc = $signed({2'b0, p[48:16]});
        sum = 35'($signed(v)) + (neg ? -inc : inc);
        l   = $signed({4'b0, lim});
        if (sum > l) sum = l;
        else if (sum < -l) sum = -l;
        return sum[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [31:0] drag_axis(input logic neg, input logic [48:0] p,
                                              input logic [30:0] thr);
        logic [32:0] m;
        logic [31:0] r;
        m = p[48:16];
        if (neg) r = (m > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
        else     r = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        if (r < {1'b0, thr}) r = '0;
        return neg ? 32'(-r) : r;
    endfunction

    logic [31:0] px0, px_b, py_b;
    logic signed [33:0] sum_x, sum_y, ww_l, wh_l;
    logic signed [16:0] dw, dh;
    always_comb
    begin
        px0   = pos_x_reg[31] || (pos_x_reg == '0) ? '0 : pos_x_reg;
        sum_x = 34'($signed(px0)) + $signed({2'b0, spr_w_reg, 16'b0});
        sum_y = 34'($signed(pos_y_reg)) + $signed({2'b0, spr_h_reg, 16'b0});
        ww_l  = $signed({2'b0, win_w_reg, 16'b0});
        wh_l  = $signed({2'b0, win_h_reg, 16'b0});
        dw    = $signed({1'b0, win_w_reg}) - $signed({1'b0, spr_w_reg});
        dh    = $signed({1'b0, win_h_reg}) - $signed({1'b0, spr_h_reg});
        px_b  = (sum_x >= ww_l) ? sat32(35'($signed({dw, 16'b0}))) : px0;
        py_b  = (sum_y >= wh_l) ? sat32(35'($signed({dh, 16'b0}))) : pos_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else if (cmd.move)
        begin
            pos_x_reg <= sat32(35'($signed(pos_x_reg)) + 35'($signed(vel_x_reg)));
            pos_y_reg <= sat32(35'($signed(pos_y_reg)) + 35'($signed(vel_y_reg)));
        end
        else if (cmd.acc_fin)
        begin
            vel_x_reg <= acc_axis(vel_x_reg, dx_reg[15], prod_x_reg, vmax_reg);
            vel_y_reg <= acc_axis(vel_y_reg, dy_reg[15], prod_y_reg, vmax_reg);
        end
        else if (cmd.drag_fin)
        begin
            vel_x_reg <= drag_axis(vel_x_reg[31], prod_x_reg, vmin_reg);
            vel_y_reg <= drag_axis(vel_y_reg[31], prod_y_reg, vmin_reg);
        end
        else if (cmd.bound)
        begin
            pos_x_reg <= px_b;
            pos_y_reg <= py_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= in_op;
            dx_reg <= $signed(in_dir_x);
            dy_reg <= $signed(in_dir_y);
        end
        if (cmd.move)
        begin
            rad_reg  <= {n2, 32'b0};
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
            q_x_reg  <= '0;
            q_y_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (take)
            begin
                rad_reg  <= rad_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        else if (cmd.div_init)
        begin
            len_reg   <= root_reg[31:0];
            rem_x_reg <= {2'b0, ax, 15'b0};
            rem_y_reg <= {2'b0, ay, 15'b0};
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= gx ? tx - {1'b0, len_reg} : tx;
            rem_y_reg <= gy ? ty - {1'b0, len_reg} : ty;
            q_x_reg   <= {q_x_reg[15:0], gx};
            q_y_reg   <= {q_y_reg[15:0], gy};
        end
        if (cmd.acc_mul)
        begin
            prod_x_reg <= 49'(q_x_reg * accel_reg);
            prod_y_reg <= 49'(q_y_reg * accel_reg);
        end
        else if (cmd.drag_mul)
        begin
            prod_x_reg <= 49'(mag32(vel_x_reg) * drag_reg);
            prod_y_reg <= 49'(mag32(vel_y_reg) * drag_reg);
        end
        if (cmd.out_load)
        begin
            out_reg <= {vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;
    assign status.op        = op_reg;
    assign status.n2_zero   = (n2 == '0);
    assign status.out_stall = out_valid_reg && !out_ready;

endmodule
`default_nettype wire

/* src/sprite_velocity_physics_step.sv */
// Top level of the sprite position and velocity physics step.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser op, tdata dir_x, dir_y
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata pos_x, pos_y, vel_x, vel_y
//  cfg      in   cfg_we                         cfg_addr, cfg_data
//
// A force beat's time from acceptance to result is set by the 32-step square
// root and the 17-step divide; with a zero direction both are skipped.
// Drag, bound and unused beats use neither the root nor the divide.
// One beat is worked on at a time; a finished result waits in the output
// register, and the next beat is taken once that result has been loaded.
// Reset clears position, velocity and control and restores the register defaults.
`default_nettype none
module sprite_velocity_physics_step
    import svps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [1:0]   s_axis_tuser,   // op
    input  wire logic [31:0]  s_axis_tdata,   // dir_x, dir_y
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    svps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser),
        .in_dir_x  (s_axis_tdata[15:0]),
        .in_dir_y  (s_axis_tdata[31:16]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the sprite position and velocity physics step.
`timescale 1ns / 1ps
module testbench;
    import svps_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;

    sprite_velocity_physics_step uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] dx;
        logic [15:0] dy;
        bit          known;
        logic [127:0] result;
    } row_t;

    logic [31:0] accel, vmax, vmin, drag, win_w, win_h, spr_w, spr_h;
    logic signed [31:0] px, py, vx, vy;
    logic [127:0] expected_q[$];
    logic [127:0] typed_q[$];
    bit           typed_valid_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit long_hold = 1'b0;

    function automatic logic signed [31:0] sat(longint v);
        if (v > SMAX) return 32'h7FFF_FFFF;
        if (v < SMIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint scale_q16(longint a, longint unsigned b);
        longint unsigned m;
        longint p;
        m = (a < 0) ? -a : a;
        p = (m * b) >> 16;
        return (a < 0) ? -p : p;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_speed(longint v);
        longint lim;
        lim = vmax;
        if (v > lim) return lim[31:0];
        if (v < -lim) return 32'(-lim);
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] drag_axis(logic signed [31:0] v);
        logic signed [31:0] r;
        longint m;
        r = sat(scale_q16(longint'(v), drag));
        m = (r < 0) ? -longint'(r) : longint'(r);
        if (m < longint'(vmin)) r = 0;
        return r;
    endfunction

    function automatic logic [127:0] physics_step(logic [1:0] op, logic [15:0] dxr,
                                                  logic [15:0] dyr);
        longint dx, dy, ux, uy, sw, sh, ww, wh;
        longint unsigned n2, len;
        dx = longint'($signed(dxr));
        dy = longint'($signed(dyr));
        ux = 0;
        uy = 0;
        if (op == OP_FORCE)
        begin
            n2 = dx * dx + dy * dy;
            px = sat(longint'(px) + longint'(vx));
            py = sat(longint'(py) + longint'(vy));
            if (n2 != 0)
            begin
                len = root64(n2 << 32);
                ux = ((((dx < 0) ? -dx : dx)) << 32) / len;
                uy = ((((dy < 0) ? -dy : dy)) << 32) / len;
                if (dx < 0) ux = -ux;
                if (dy < 0) uy = -uy;
            end
            vx = clamp_speed(longint'(vx) + scale_q16(ux, accel));
            vy = clamp_speed(longint'(vy) + scale_q16(uy, accel));
        end
        else if (op == OP_DRAG)
        begin
            vx = drag_axis(vx);
            vy = drag_axis(vy);
        end
        else if (op == OP_BOUND)
        begin
            sw = longint'(spr_w) * 65536;
            sh = longint'(spr_h) * 65536;
            ww = longint'(win_w) * 65536;
            wh = longint'(win_h) * 65536;
            if (px <= 0) px = 0;
            if (longint'(px) + sw >= ww) px = sat(ww - sw);
            if (longint'(py) + sh >= wh) py = sat(wh - sh);
        end
        return {vy, vx, py, px};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_ACCEL: accel = val;
            REG_VMAX:  vmax  = val & 32'h7FFF_FFFF;
            REG_VMIN:  vmin  = val & 32'h7FFF_FFFF;
            REG_DRAG:  drag  = val & 32'h1_FFFF;
            REG_WIN_W: win_w = val & 32'hFFFF;
            REG_WIN_H: win_h = val & 32'hFFFF;
            REG_SPR_W: spr_w = val & 32'hFFFF;
            default:   spr_h = val & 32'hFFFF;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic send_beat(logic [1:0] op, logic [15:0] dx, logic [15:0] dy,
                             bit known, logic [127:0] typed, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dy, dx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_q.push_back(physics_step(op, dx, dy));
        typed_q.push_back(typed);
        typed_valid_q.push_back(known);
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        int k;
        logic [1:0] op;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_FORCE;
                4, 5, 6:    op = OP_DRAG;
                7, 8:       op = OP_BOUND;
                default:    op = OP_NOP;
            endcase
            send_beat(op, rand_dir(), rand_dir(), 1'b0, '0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || long_hold)
            m_axis_tready <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            rx_wait = $urandom_range(0, 10);
            m_axis_tready <= (rx_wait == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait = rx_wait - 1;
            m_axis_tready <= (rx_wait == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [127:0] exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", m_axis_tdata);
            end
            else
            begin
                exp_beat = expected_q.pop_front();
                if (typed_valid_q.pop_front())
                begin
                    if (typed_q[0] !== exp_beat)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("table row %h, predicted %h", typed_q[0], exp_beat);
                    end
                end
                void'(typed_q.pop_front());
                for (int f = 0; f < 4; f++)
                    if (m_axis_tdata[f*32 +: 32] !== exp_beat[f*32 +: 32])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("field %0d: expected %h, got %h", f,
                                     exp_beat[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("sprite_velocity_physics_step: mismatch");
            $finish;
        end
    end

    row_t rows[$];

    initial
    begin
        accel = 65536; vmax = 655360; vmin = 6554; drag = 62259;
        win_w = 800; win_h = 600; spr_w = 32; spr_h = 32;
        px = 0; py = 0; vx = 0; vy = 0;
        rows = '{
            '{OP_NOP, 16'h0000, 16'h0000, 1'b1, 128'h0},
            '{OP_FORCE, 16'h0000, 16'h0000, 1'b1, 128'h0},
            '{OP_FORCE, 16'h0001, 16'h0000, 1'b1, {32'h0, 32'h0001_0000, 64'h0}},
            '{OP_FORCE, 16'h8000, 16'h0000, 1'b0, '0},
            '{OP_FORCE, 16'h7FFF, 16'h7FFF, 1'b0, '0},
            '{OP_FORCE, 16'h8000, 16'h8000, 1'b0, '0},
            '{OP_FORCE, 16'h0000, 16'hFFFF, 1'b0, '0},
            '{OP_DRAG, 16'h0000, 16'h0000, 1'b0, '0},
            '{OP_BOUND, 16'hFFFF, 16'hFFFF, 1'b0, '0},
            '{OP_FORCE, 16'h1234, 16'hEDCB, 1'b0, '0},
            '{OP_DRAG, 16'hFFFF, 16'h0000, 1'b0, '0},
            '{OP_BOUND, 16'h0000, 16'h0000, 1'b0, '0},
            '{OP_NOP, 16'hFFFF, 16'hFFFF, 1'b0, '0}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].dx, rows[i].dy, rows[i].known, rows[i].result, 1'b0);
        wait_drained();

        // Speed up, then push the sprite past the window edges.
        write_reg(REG_ACCEL, 32'hFFFF_FFFF);
        write_reg(REG_VMAX, 32'h7FFF_FFFF);
        write_reg(REG_DRAG, 32'h1_0000);
        write_reg(REG_VMIN, 32'h0);
        random_phase(300);
        wait_drained();

        write_reg(REG_DRAG, 32'h1_FFFF);
        write_reg(REG_SPR_W, 32'hFFFF);
        write_reg(REG_WIN_W, 32'h0);
        write_reg(REG_WIN_H, 32'hFFFF);
        write_reg(REG_SPR_H, 32'h0);
        random_phase(300);
        wait_drained();

        write_reg(REG_ACCEL, 32'h0);
        write_reg(REG_VMAX, 32'h0);
        write_reg(REG_VMIN, 32'h7FFF_FFFF);
        write_reg(REG_DRAG, 32'h0);
        random_phase(100);
        wait_drained();

        write_reg(REG_ACCEL, 32'h0004_0000);
        write_reg(REG_VMAX, 32'h0010_0000);
        write_reg(REG_VMIN, 32'h0000_1000);
        write_reg(REG_DRAG, 32'h0_F000);
        write_reg(REG_WIN_W, 32'd640);
        write_reg(REG_WIN_H, 32'd480);
        write_reg(REG_SPR_W, 32'd16);
        write_reg(REG_SPR_H, 32'd24);
        long_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_beat(OP_DRAG, 16'h0, 16'h0, 1'b0, '0, 1'b1);
        join
        random_phase(450);
        wait_drained();
        for (int k = 0; k < 40; k++)
            send_beat($urandom_range(0, 1) ? OP_FORCE : OP_DRAG, rand_dir(), rand_dir(),
                      1'b0, '0, 1'b1);
        random_phase(400);
        wait_drained();

        if (errors == 0)
            $display("sprite_velocity_physics_step: match");
        else
            $display("sprite_velocity_physics_step: mismatch");
        $finish;
    end
endmodule
